// ----- rtl/btec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package btec_pkg;

    // Field widths of one input item
    localparam int ACT_W    = 2;
    localparam int VAR_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int TOTAL_W  = 5;
    localparam int NUM_W    = 32;
    localparam int LADDR_W  = 12;
    localparam int LCOUNT_W = 16;

    // Bit offsets inside s_tdata
    localparam int OFF_VAR    = 0;
    localparam int OFF_SLOT   = OFF_VAR + VAR_W;
    localparam int OFF_TOTAL  = OFF_SLOT + SLOT_W;
    localparam int OFF_NUM    = OFF_TOTAL + TOTAL_W;
    localparam int OFF_LADDR  = OFF_NUM + NUM_W;
    localparam int OFF_LCOUNT = OFF_LADDR + LADDR_W;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    // Configuration registers
    localparam int THR_W      = 17;
    localparam int TREES_W    = 16;
    localparam int VCNT_W     = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TREES     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VARS      = 2'd2;

    // Vote fraction scaling (Q1.16 threshold)
    localparam int FRAC_W = 16;

    // Feature position counter saturates here
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_SAT = '1;

    localparam logic [TOTAL_W-1:0] SPLIT_CNT_RST = '1;

    // Command queue between front and back (power of two)
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_SPLIT = 2'd0,
        ACT_COUNT = 2'd1,
        ACT_LEAF  = 2'd2,
        ACT_FEAT  = 2'd3
    } action_t;

    typedef struct packed {
        action_t               kind;
        logic [VAR_W-1:0]      var_sel;
        logic [SLOT_W-1:0]     slot;
        logic [TOTAL_W-1:0]    split_total;
        logic [NUM_W-1:0]      number;
        logic [LADDR_W-1:0]    leaf_addr;
        logic [LCOUNT_W-1:0]   leaf_count;
        logic                  last;
    } cmd_t;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [TREES_W-1:0] trees;
        logic [VCNT_W-1:0]  vars;
    } cfg_t;

    typedef struct packed {
        logic                decision;
        logic [LCOUNT_W-1:0] votes;
        logic                fault;
    } result_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_INDEX,
        BK_LOOK,
        BK_DECIDE
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/btec_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btec_front #(
    parameter int MAX_VARS   = 8,
    parameter int MAX_SPLITS = 16,
    parameter int LEAF_DEPTH = 4096
) (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [btec_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [btec_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                           s_tlast,
    input  wire logic                           fifo_full,
    input  wire logic                           clearing,
    output logic                                push,
    output btec_pkg::cmd_t                      cmd
);
    import btec_pkg::*;

    logic var_ok;
    logic slot_ok;
    logic leaf_ok;
    logic keep;

    always_comb begin
        cmd.kind        = action_t'(s_tuser[ACT_W-1:0]);
        cmd.var_sel     = s_tdata[OFF_VAR +: VAR_W];
        cmd.slot        = s_tdata[OFF_SLOT +: SLOT_W];
        cmd.split_total = s_tdata[OFF_TOTAL +: TOTAL_W];
        cmd.number      = s_tdata[OFF_NUM +: NUM_W];
        cmd.leaf_addr   = s_tdata[OFF_LADDR +: LADDR_W];
        cmd.leaf_count  = s_tdata[OFF_LCOUNT +: LCOUNT_W];
        cmd.last        = s_tlast;
    end

    // Out-of-range loads are taken and dropped here
    assign var_ok  = 32'(cmd.var_sel) < 32'(MAX_VARS);
    assign slot_ok = 32'(cmd.slot) < 32'(MAX_SPLITS);
    assign leaf_ok = 32'(cmd.leaf_addr) < 32'(LEAF_DEPTH);

    always_comb begin
        case (cmd.kind)
            ACT_SPLIT: keep = var_ok && slot_ok;
            ACT_COUNT: keep = var_ok;
            ACT_LEAF:  keep = leaf_ok;
            ACT_FEAT:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign s_tready = !fifo_full && !clearing;
    assign push     = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

// ----- rtl/btec_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btec_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  btec_pkg::cmd_t      din,
    input  wire logic           pop,
    output btec_pkg::cmd_t      dout,
    output logic                full,
    output logic                empty
);
    import btec_pkg::*;

    cmd_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = cnt_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

// ----- rtl/btec_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btec_back #(
    parameter int MAX_VARS   = 8,
    parameter int MAX_SPLITS = 16,
    parameter int LEAF_DEPTH = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  btec_pkg::cfg_t    cfg,
    input  wire logic         fifo_empty,
    input  btec_pkg::cmd_t    head,
    output logic              fifo_pop,
    output logic              clearing,
    output logic              m_valid,
    input  wire logic         m_ready,
    output btec_pkg::result_t m_result
);
    import btec_pkg::*;

    localparam int IW    = $clog2(LEAF_DEPTH);
    localparam int SW    = $clog2(MAX_SPLITS);
    localparam int CW    = $clog2(MAX_SPLITS + 1);
    localparam int VW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int SAW   = $clog2(MAX_VARS * MAX_SPLITS);
    localparam int PW    = IW + CW + 1;
    localparam int PRODW = THR_W + TREES_W;

    // Memories
    logic [NUM_W-1:0]    split_mem [MAX_VARS * MAX_SPLITS];
    logic [LCOUNT_W-1:0] leaf_mem  [LEAF_DEPTH];
    logic [NUM_W-1:0]    split_rd_reg;
    logic [LCOUNT_W-1:0] leaf_rd_reg;

    // Control state
    back_state_t         state_reg;
    back_state_t         state_next;
    logic [TOTAL_W-1:0]  split_cnt_reg [MAX_VARS];
    logic [IW-1:0]       clr_addr_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [IW-1:0]       partial_reg;
    logic                index_over_reg;
    logic                count_bad_reg;
    logic                m_valid_reg;

    // Per-feature working registers
    logic [NUM_W-1:0]    feat_reg;
    logic                last_reg;
    logic [POS_W-1:0]    cur_pos_reg;
    logic [CW-1:0]       eff_reg;
    logic [SAW-1:0]      row_base_reg;
    logic [SW-1:0]       scan_s_reg;
    logic [SW-1:0]       bin_reg;
    logic                fault_reg;
    logic [PRODW-1:0]    prod_reg;
    result_t             result_reg;

    logic [31:0]         pos_w;
    logic [31:0]         head_var_w;
    logic [31:0]         head_laddr_w;
    logic [31:0]         cnt_w;
    logic [31:0]         eff_w;
    logic [CW-1:0]       eff_new;
    logic [SAW-1:0]      row_base_new;
    logic                pos_bad;
    logic                feat_skip;
    logic                is_feat;
    logic                hit;
    logic                scan_end;
    logic [PW-1:0]       p_sum;
    logic                p_over;
    logic                fault_now;
    logic                out_free;
    logic [LCOUNT_W-1:0] votes_sel;
    logic                decision_new;
    logic [TREES_W-1:0]  trees_eff;

    logic                split_we;
    logic [SAW-1:0]      split_waddr;
    logic                split_re;
    logic [SAW-1:0]      split_raddr;
    logic                cnt_we;
    logic                leaf_we;
    logic [IW-1:0]       leaf_waddr;
    logic [LCOUNT_W-1:0] leaf_wdata;
    logic                leaf_re;

    assign pos_w        = 32'(pos_reg);
    assign head_var_w   = 32'(head.var_sel);
    assign head_laddr_w = 32'(head.leaf_addr);
    assign cnt_w        = 32'(split_cnt_reg[pos_w[VW-1:0]]);

    // Stored count 0 means 1, above MAX_SPLITS means MAX_SPLITS
    always_comb begin
        if (cnt_w == 32'd0) begin
            eff_w = 32'd1;
        end else if (cnt_w > 32'(MAX_SPLITS)) begin
            eff_w = 32'(MAX_SPLITS);
        end else begin
            eff_w = cnt_w;
        end
    end

    assign eff_new      = eff_w[CW-1:0];
    assign row_base_new = SAW'(pos_w * 32'(MAX_SPLITS));
    assign pos_bad      = (pos_w >= 32'(cfg.vars)) || (pos_w >= 32'(MAX_VARS));
    assign feat_skip    = pos_bad || index_over_reg;
    assign is_feat      = head.kind == ACT_FEAT;

    assign hit      = $signed(feat_reg) < $signed(split_rd_reg);
    assign scan_end = (32'(scan_s_reg) + 32'd1) == 32'(eff_reg);

    assign p_sum  = PW'(partial_reg) * PW'(eff_reg) + PW'(bin_reg);
    assign p_over = p_sum >= PW'(LEAF_DEPTH);

    assign fault_now = count_bad_reg || index_over_reg ||
                       ((POS_W + 1)'(cur_pos_reg) + 1'b1 != (POS_W + 1)'(cfg.vars));

    assign out_free     = !m_valid_reg || m_ready;
    assign votes_sel    = fault_reg ? '0 : leaf_rd_reg;
    assign decision_new = !fault_reg && (PRODW'({votes_sel, FRAC_W'(0)}) > prod_reg);
    assign trees_eff    = (cfg.trees == '0) ? TREES_W'(1) : cfg.trees;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR: begin
                if (clr_addr_reg == IW'(LEAF_DEPTH - 1)) state_next = BK_IDLE;
            end
            BK_IDLE: begin
                if (!fifo_empty && is_feat) begin
                    if (!feat_skip) begin
                        state_next = BK_SCAN;
                    end else if (head.last) begin
                        state_next = BK_LOOK;
                    end
                end
            end
            BK_SCAN: begin
                if (hit || scan_end) state_next = BK_INDEX;
            end
            BK_INDEX: begin
                state_next = last_reg ? BK_LOOK : BK_IDLE;
            end
            BK_LOOK: begin
                state_next = BK_DECIDE;
            end
            BK_DECIDE: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Memory and queue controls
    always_comb begin
        clearing    = state_reg == BK_CLEAR;
        fifo_pop    = (state_reg == BK_IDLE) && !fifo_empty;
        split_we    = fifo_pop && (head.kind == ACT_SPLIT);
        split_waddr = SAW'(head_var_w * 32'(MAX_SPLITS) + 32'(head.slot));
        cnt_we      = fifo_pop && (head.kind == ACT_COUNT);
        leaf_we     = clearing || (fifo_pop && (head.kind == ACT_LEAF));
        leaf_waddr  = clearing ? clr_addr_reg : head_laddr_w[IW-1:0];
        leaf_wdata  = clearing ? '0 : head.leaf_count;
        leaf_re     = state_reg == BK_LOOK;
        if (state_reg == BK_SCAN) begin
            split_re    = !scan_end;
            split_raddr = SAW'(32'(row_base_reg) + 32'(scan_s_reg) + 32'd1);
        end else begin
            split_re    = fifo_pop && is_feat && !feat_skip;
            split_raddr = row_base_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (split_we) split_mem[split_waddr] <= head.number;
        if (split_re) split_rd_reg <= split_mem[split_raddr];
    end

    always_ff @(posedge aclk) begin
        if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
        if (leaf_re) leaf_rd_reg <= leaf_mem[partial_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_CLEAR;
            clr_addr_reg   <= '0;
            pos_reg        <= '0;
            partial_reg    <= '0;
            index_over_reg <= 1'b0;
            count_bad_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int v = 0; v < MAX_VARS; v++) begin
                split_cnt_reg[v] <= SPLIT_CNT_RST;
            end
        end else begin
            state_reg <= state_next;
            if (clearing) clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cnt_we) split_cnt_reg[head_var_w[VW-1:0]] <= head.split_total;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                BK_IDLE: begin
                    if (fifo_pop && is_feat) begin
                        if (pos_reg != POS_SAT) pos_reg <= pos_reg + 1'b1;
                        if (pos_bad) count_bad_reg <= 1'b1;
                    end
                end
                BK_INDEX: begin
                    if (p_over) begin
                        index_over_reg <= 1'b1;
                        partial_reg    <= '0;
                    end else begin
                        partial_reg <= p_sum[IW-1:0];
                    end
                end
                BK_DECIDE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        pos_reg        <= '0;
                        partial_reg    <= '0;
                        index_over_reg <= 1'b0;
                        count_bad_reg  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= PRODW'(cfg.threshold) * PRODW'(trees_eff);
        case (state_reg)
            BK_IDLE: begin
                if (fifo_pop && is_feat) begin
                    feat_reg     <= head.number;
                    last_reg     <= head.last;
                    cur_pos_reg  <= pos_reg;
                    eff_reg      <= eff_new;
                    row_base_reg <= row_base_new;
                    scan_s_reg   <= '0;
                end
            end
            BK_SCAN: begin
                // first split above the feature closes the bin
                if (hit) begin
                    bin_reg <= (scan_s_reg == '0) ? '0 : scan_s_reg - 1'b1;
                end else begin
                    bin_reg <= scan_s_reg;
                end
                scan_s_reg <= scan_s_reg + 1'b1;
            end
            BK_LOOK: begin
                fault_reg <= fault_now;
            end
            BK_DECIDE: begin
                if (out_free) begin
                    result_reg.decision <= decision_new;
                    result_reg.votes    <= votes_sel;
                    result_reg.fault    <= fault_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/binned_tree_ensemble_classifier_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Binned decision-tree ensemble classifier.
// s_ channel: one item per handshake. s_tuser = action (load split value, set split
//   count, load leaf votes, classify feature); s_tlast marks the final feature.
//   Load items fill the split table, the split counts and the leaf vote table.
//   Feature items arrive in variable order, get binned and build the leaf index.
// m_ channel: one item per final feature: decision, votes and the fault flag.
// cfg_ port: plain register writes (threshold, tree count, variable count),
//   only while no classification is in flight.
// Timing: the front takes an item per cycle into a 2-entry command queue unless
//   it is full or the leaf table is being cleared; the back drains it, writing a
//   load item as it pops it. A feature is binned by the split-table scan (one memory
//   read per cycle), which stops at the first split above it or the last counted split.
//   The final feature adds a leaf read and a compare before the result shows on m_tvalid.
// Reset: after aresetn the back sweeps the leaf table to zero with s_tready low;
//   cfg writes are taken meanwhile.
// Stall: a result waits in the output register while m_tready is low; the back
//   keeps working on queued items until the next result has to be written.
module binned_tree_ensemble_classifier_core #(
    parameter int MAX_VARS   = 8,
    parameter int MAX_SPLITS = 16,
    parameter int LEAF_DEPTH = 4096
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // item in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // var_sel[2:0], slot[6:3], split_total[11:7], number[43:12],
    // leaf_addr[55:44], leaf_count[71:56]
    input  wire logic [btec_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  wire logic [btec_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                            s_tlast,
    // result out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // decision[0], votes[16:1], zero fill[23:17]
    output logic [btec_pkg::M_TDATA_W-1:0]       m_tdata,
    // fault[0]
    output logic [btec_pkg::M_TUSER_W-1:0]       m_tuser,
    // configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [btec_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [btec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import btec_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    front_cmd;
    cmd_t    head_cmd;
    result_t result;
    logic    push;
    logic    fifo_full;
    logic    fifo_empty;
    logic    fifo_pop;
    logic    clearing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= '0;
            cfg_reg.trees     <= TREES_W'(1);
            cfg_reg.vars      <= VCNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_wdata[THR_W-1:0];
                CFG_TREES:     cfg_reg.trees     <= cfg_wdata[TREES_W-1:0];
                CFG_VARS:      cfg_reg.vars      <= cfg_wdata[VCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    btec_front #(
        .MAX_VARS   (MAX_VARS),
        .MAX_SPLITS (MAX_SPLITS),
        .LEAF_DEPTH (LEAF_DEPTH)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .clearing  (clearing),
        .push      (push),
        .cmd       (front_cmd)
    );

    btec_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (front_cmd),
        .pop     (fifo_pop),
        .dout    (head_cmd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    btec_back #(
        .MAX_VARS   (MAX_VARS),
        .MAX_SPLITS (MAX_SPLITS),
        .LEAF_DEPTH (LEAF_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .head       (head_cmd),
        .fifo_pop   (fifo_pop),
        .clearing   (clearing),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (result)
    );

    assign m_tdata = M_TDATA_W'({result.votes, result.decision});
    assign m_tuser = M_TUSER_W'(result.fault);

endmodule

`default_nettype wire

// ----- rtl/btec_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btec_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [btec_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire logic                            s_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [btec_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [btec_pkg::M_TUSER_W-1:0]  m_tuser
);
    import btec_pkg::*;

    // leaf table sweep follows reset: no items taken right away
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("item path open right after reset");

    // held result must not change
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a fault carries no decision and no votes
    a_fault_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("fault result with payload");

    // a positive decision needs some votes
    a_decision_votes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[LCOUNT_W:1] != '0)
        else $error("decision set with zero votes");

endmodule

bind binned_tree_ensemble_classifier_core btec_checker u_btec_checker (.*);

`default_nettype wire

// ----- verif/btec_verdict_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams and the cfg port, keeps its own copy of the tables,
// predicts each verdict and compares it with what comes out of m_.
module btec_verdict_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [btec_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [btec_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                            s_tlast,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [btec_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic [btec_pkg::M_TUSER_W-1:0]  m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [btec_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [btec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                   fail_count,
    output int                                   verdicts_due
);
    import btec_pkg::*;

    localparam int MAX_VARS   = 8;
    localparam int MAX_SPLITS = 16;
    localparam int LEAF_DEPTH = 4096;

    logic signed [NUM_W-1:0] split_val [MAX_VARS][MAX_SPLITS];
    logic [TOTAL_W-1:0]      split_num [MAX_VARS];
    logic [LCOUNT_W-1:0]     leaf_votes [LEAF_DEPTH];
    int unsigned             leaf_index;
    logic [POS_W-1:0]        feat_pos;
    bit                      index_over;
    bit                      count_bad;
    logic [THR_W-1:0]        thr;
    logic [TREES_W-1:0]      trees;
    logic [VCNT_W-1:0]       vars;
    result_t                 verdict_q [$];

    // split count as used: 0 acts as 1, anything above the table as the table
    function automatic int unsigned split_depth(input int unsigned v);
        int unsigned c;
        c = split_num[v];
        if (c == 0) c = 1;
        if (c > MAX_SPLITS) c = MAX_SPLITS;
        return c;
    endfunction

    function automatic int unsigned feature_bin(input int unsigned v,
                                                input logic signed [NUM_W-1:0] f);
        int unsigned n;
        n = split_depth(v);
        if (f < split_val[v][0]) return 0;
        for (int s = 1; s < n; s++)
            if (f < split_val[v][s]) return s - 1;
        return n - 1;
    endfunction

    always @(posedge aclk) begin : watch
        int unsigned v;
        int unsigned pos;
        logic signed [NUM_W-1:0] num;
        longint nxt;
        longint tc;
        result_t want;
        result_t got;

        if (!aresetn) begin
            foreach (split_val[i, j]) split_val[i][j] = '0;
            foreach (split_num[i]) split_num[i] = SPLIT_CNT_RST;
            foreach (leaf_votes[i]) leaf_votes[i] = '0;
            leaf_index = 0;
            feat_pos   = '0;
            index_over = 0;
            count_bad  = 0;
            thr        = '0;
            trees      = 16'd1;
            vars       = 4'd1;
            verdict_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.decision = m_tdata[0];
                got.votes    = m_tdata[16:1];
                got.fault    = m_tuser[0];
                if (verdict_q.size() == 0) begin
                    $error("unexpected result item: decision %0d votes %0d fault %0d",
                           got.decision, got.votes, got.fault);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (got.decision !== want.decision) begin
                        $error("decision: expected %0d, got %0d", want.decision, got.decision);
                        fail_count++;
                    end
                    if (got.votes !== want.votes) begin
                        $error("votes: expected %0d, got %0d", want.votes, got.votes);
                        fail_count++;
                    end
                    if (got.fault !== want.fault) begin
                        $error("fault: expected %0d, got %0d", want.fault, got.fault);
                        fail_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:17] !== '0) begin
                        $error("zero fill: expected 0, got %0h", m_tdata[M_TDATA_W-1:17]);
                        fail_count++;
                    end
                end
            end

            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_THRESHOLD: thr   = cfg_wdata[THR_W-1:0];
                    CFG_TREES:     trees = cfg_wdata[TREES_W-1:0];
                    CFG_VARS:      vars  = cfg_wdata[VCNT_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                v   = s_tdata[OFF_VAR +: VAR_W];
                num = s_tdata[OFF_NUM +: NUM_W];
                case (action_t'(s_tuser))
                    ACT_SPLIT: split_val[v][s_tdata[OFF_SLOT +: SLOT_W]] = num;
                    ACT_COUNT: split_num[v] = s_tdata[OFF_TOTAL +: TOTAL_W];
                    ACT_LEAF:  leaf_votes[s_tdata[OFF_LADDR +: LADDR_W]] =
                                   s_tdata[OFF_LCOUNT +: LCOUNT_W];
                    ACT_FEAT: begin
                        pos = feat_pos;
                        if (pos >= vars || pos >= MAX_VARS) begin
                            count_bad = 1;
                        end else if (!index_over) begin
                            // mixed radix, last variable least significant
                            nxt = longint'(leaf_index) * split_depth(pos)
                                + feature_bin(pos, num);
                            if (nxt >= LEAF_DEPTH) begin
                                index_over = 1;
                                leaf_index = 0;
                            end else begin
                                leaf_index = nxt;
                            end
                        end
                        if (feat_pos != POS_SAT) feat_pos++;
                        if (s_tlast) begin
                            want       = '0;
                            want.fault = count_bad || index_over || (pos + 1 != vars);
                            if (!want.fault) begin
                                tc = (trees == 0) ? 1 : trees;
                                want.votes    = leaf_votes[leaf_index];
                                want.decision = (longint'(want.votes) * 65536
                                                 > longint'(thr) * tc);
                            end
                            verdict_q.push_back(want);
                            leaf_index = 0;
                            feat_pos   = '0;
                            index_over = 0;
                            count_bad  = 0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        verdicts_due = verdict_q.size();
    end

endmodule

// ----- verif/tb_binned_tree_ensemble_classifier_core.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the binned tree ensemble core. All prediction and
// comparison lives in btec_verdict_checker; this module drives items, cfg writes and m_tready.
module tb_binned_tree_ensemble_classifier_core;
    import btec_pkg::*;

    localparam int HOLD_CYCLES   = 400;  // long m_tready hold-off
    localparam int SETTLE_CYCLES = 64;   // back drains queued loads after last result
    localparam int N_PHASES      = 8;

    // per-phase register settings and item budgets
    int phase_thr   [N_PHASES] = '{32768, 0, 65536, 131071, 20000, 45000, 10000, 5000};
    int phase_trees [N_PHASES] = '{100, 1, 65535, 1, 7, 300, 50, 9};
    int phase_vars  [N_PHASES] = '{3, 8, 4, 2, 5, 1, 0, 12};
    int phase_len   [N_PHASES] = '{110, 110, 110, 100, 110, 100, 40, 40};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int verdicts_due;

    bit calm;                 // no idling on either side while set
    int hold_req     = 0;     // bumped by stimulus to ask for a hold-off
    int hold_done    = 0;
    int items_pushed = 0;

    // what the stimulus believes is loaded, used only to aim features
    logic signed [NUM_W-1:0] split_shadow [8][16];
    logic [THR_W-1:0]        cur_thr;
    logic [TREES_W-1:0]      cur_trees;
    logic [VCNT_W-1:0]       cur_vars;

    binned_tree_ensemble_classifier_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    btec_verdict_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .verdicts_due (verdicts_due)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // hard stop well past the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("tb_binned_tree_ensemble_classifier_core: errors");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin : sink
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req != hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done++;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // every field random; callers override what matters for the action
    function automatic cmd_t noise_cmd();
        logic [95:0] r;
        cmd_t c;
        r = {$urandom(), $urandom(), $urandom()};
        c = r[$bits(cmd_t)-1:0];
        return c;
    endfunction

    // split counts: mostly small so the leaf index stays in the table,
    // with zero and oversize counts mixed in
    function automatic logic [TOTAL_W-1:0] pick_split_total();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 3);
        if (r == 7) return $urandom_range(4, 16);
        if (r == 8) return '0;
        return $urandom_range(17, 31);
    endfunction

    // feature aimed on or next to a stored split, or a wild / extreme value
    function automatic logic [NUM_W-1:0] feature_value(input int v);
        int r;
        int d;
        r = $urandom_range(0, 9);
        d = $urandom_range(0, 2);
        if (v < 8 && r < 6) return split_shadow[v][$urandom_range(0, 15)] + d - 1;
        if (r == 9) begin
            if (d == 0) return 32'h8000_0000;
            if (d == 1) return 32'h7FFF_FFFF;
            return '0;
        end
        return $urandom();
    endfunction

    // leaf vote count around the decision boundary of the current settings
    function automatic logic [LCOUNT_W-1:0] near_boundary();
        longint b;
        b = (longint'(cur_thr) * ((cur_trees == 0) ? 1 : cur_trees)) >>> FRAC_W;
        b = b - 3 + $urandom_range(0, 6);
        if (b < 0) b = 0;
        if (b > 65535) b = 65535;
        return b[LCOUNT_W-1:0];
    endfunction

    // offer one item; returns on the falling edge after it was taken
    task automatic push_item(input cmd_t c);
        if (!calm) begin
            while ($urandom_range(0, 99) < 37) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tdata  <= {c.leaf_count, c.leaf_addr, c.number, c.split_total, c.slot, c.var_sel};
        s_tuser  <= c.kind;
        s_tlast  <= c.last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_pushed++;
        @(negedge aclk);
    endtask

    task automatic send_feature(input logic [NUM_W-1:0] num, input bit last);
        cmd_t c;
        c        = noise_cmd();
        c.kind   = ACT_FEAT;
        c.number = num;
        c.last   = last;
        push_item(c);
    endtask

    task automatic send_leaf(input logic [LADDR_W-1:0] addr,
                             input logic [LCOUNT_W-1:0] count);
        cmd_t c;
        c            = noise_cmd();
        c.kind       = ACT_LEAF;
        c.leaf_addr  = addr;
        c.leaf_count = count;
        push_item(c);
    endtask

    task automatic send_splits(input logic [VAR_W-1:0] v, input logic [TOTAL_W-1:0] total);
        cmd_t c;
        c             = noise_cmd();
        c.kind        = ACT_COUNT;
        c.var_sel     = v;
        c.split_total = total;
        push_item(c);
    endtask

    task automatic send_split_value(input logic [VAR_W-1:0] v, input logic [SLOT_W-1:0] s,
                                    input logic [NUM_W-1:0] num);
        cmd_t c;
        c         = noise_cmd();
        c.kind    = ACT_SPLIT;
        c.var_sel = v;
        c.slot    = s;
        c.number  = num;
        split_shadow[v][s] = num;
        push_item(c);
    endtask

    task automatic random_load();
        int r;
        logic [VAR_W-1:0] v;
        logic [SLOT_W-1:0] s;
        r = $urandom_range(0, 9);
        v = $urandom_range(0, 7);
        s = $urandom_range(0, 15);
        if (r < 3) begin
            if ($urandom_range(0, 1) == 0)
                send_split_value(v, s, split_shadow[v][s] + $urandom_range(0, 131072) - 65536);
            else
                send_split_value(v, s, $urandom());
        end else if (r < 5) begin
            send_splits(v, pick_split_total());
        end else begin
            // mostly low addresses, where small split counts put the index
            send_leaf(($urandom_range(0, 3) != 0) ? $urandom_range(0, 255) : $urandom(),
                      ($urandom_range(0, 3) != 0) ? near_boundary() : $urandom());
        end
    endtask

    // n features in variable order, loads sprinkled in between
    task automatic classify(input int n);
        for (int p = 0; p < n; p++) begin
            if ($urandom_range(0, 4) == 0) random_load();
            send_feature(feature_value(p), p == n - 1);
        end
    endtask

    // sender goes quiet until every verdict is back and the back has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdicts_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // idle, then write all three registers; upper data bits of the tree and variable writes carry junk
    task automatic apply_settings(input logic [THR_W-1:0] t, input logic [TREES_W-1:0] n,
                                  input logic [VCNT_W-1:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_THRESHOLD;
        cfg_wdata <= t;
        @(negedge aclk);
        cfg_addr  <= CFG_TREES;
        cfg_wdata <= {1'($urandom()), n};
        @(negedge aclk);
        cfg_addr  <= CFG_VARS;
        cfg_wdata <= {13'($urandom()), v};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        cur_thr   = t;
        cur_trees = n;
        cur_vars  = v;
    endtask

    initial begin : stimulus
        int start;
        int r;
        int base;
        int stride;
        bit paused;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        calm      = 1'b0;
        cur_thr   = '0;
        cur_trees = 16'd1;
        cur_vars  = 4'd1;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill every split entry first, ascending per variable, so no
        // classification can ever touch an unwritten entry. push_item also
        // waits out the leaf clearing pass behind s_tready.
        for (int v = 0; v < 8; v++) begin
            base   = (int'($urandom_range(0, 400)) - 200) * 65536;
            stride = $urandom_range(16384, 524288);
            for (int s = 0; s < 16; s++) send_split_value(v, s, base + s * stride);
        end

        // --- directed, reset register values: threshold 0, one tree, one variable
        send_leaf(12'd15, 16'd1);
        send_leaf(12'd3, 16'hFFFF);
        send_leaf(12'hFFF, 16'hFFFF);
        send_feature(32'h8000_0000, 1'b1);          // most negative, bin 0, no votes
        send_feature(32'h7FFF_FFFF, 1'b1);          // reset count acts as 16: bin 15
        send_feature(split_shadow[0][3], 1'b1);     // equal to a split lands in its bin
        send_feature($urandom(), 1'b0);             // too many features: fault
        send_feature($urandom(), 1'b1);
        send_splits(3'd0, 5'd0);                    // zero count acts as one
        send_feature(32'h7FFF_FFFF, 1'b1);
        send_splits(3'd0, 5'd20);                   // oversize count clamps
        send_feature(32'h7FFF_FFFF, 1'b1);

        // --- directed, two variables, zero tree count, threshold of exactly 1.0
        apply_settings(17'd65536, 16'd0, 4'd2);
        send_splits(3'd0, 5'd2);
        send_splits(3'd1, 5'd3);
        send_leaf(12'd2, 16'd2);
        send_feature(32'h7FFF_FFFF, 1'b0);
        send_leaf(12'd4, 16'd7);                    // load in the middle of a run
        send_feature(split_shadow[1][1], 1'b1);     // index 1*3+1
        send_feature(32'h8000_0000, 1'b0);
        send_feature(32'h7FFF_FFFF, 1'b1);          // index 2, votes 2 above 1.0
        send_feature($urandom(), 1'b1);             // too few features: fault
        classify(3);                                // too many: fault

        // --- random phases
        for (int ph = 0; ph < N_PHASES; ph++) begin
            apply_settings(phase_thr[ph], phase_trees[ph], phase_vars[ph]);
            calm = (ph == 4);
            if (ph == 2) hold_req++;                // sink stalls while we keep offering
            for (int v = 0; v < 8; v++) send_splits(v, pick_split_total());
            start  = items_pushed;
            paused = 0;
            while (items_pushed - start < phase_len[ph]) begin
                if (ph == 5 && !paused && items_pushed - start >= phase_len[ph] / 2) begin
                    settle();                       // drain fully mid-phase
                    paused = 1;
                end
                r = $urandom_range(0, 9);
                if (r < 7)
                    classify((cur_vars >= 1 && cur_vars <= 8) ? int'(cur_vars)
                                                              : int'($urandom_range(1, 10)));
                else if (r == 7)
                    classify($urandom_range(1, 10));
                else if (r == 8)
                    random_load();
                else
                    push_item(noise_cmd());
            end
            // close whatever run noise may have left open before the next write
            send_feature(feature_value(0), 1'b1);
        end

        settle();
        if (fail_count == 0)
            $display("tb_binned_tree_ensemble_classifier_core: clean");
        else
            $display("tb_binned_tree_ensemble_classifier_core: errors");
        $finish;
    end

endmodule
